>>> sv/qwt_pkg.sv
// Shared types and constants for the quoted word tokenizer.
// No dependencies; every other file in the block imports this package.
`timescale 1ns / 1ps

package qwt_pkg;

	localparam int MAX_WORD_DEF = 256;
	localparam int QDEPTH       = 4;
	localparam int QPTR_W       = $clog2(QDEPTH);
	localparam int QCNT_W       = $clog2(QDEPTH + 1);

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_LINE = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LBR   = 8'h7B;
	localparam logic [7:0] CH_RBR   = 8'h7D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef struct packed {
		logic [7:0] ch;
		logic       line_end;
	} qwt_in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] word_char;
		logic       last;
	} qwt_out_t;

	typedef struct packed {
		qwt_out_t res;
		logic     two;
	} qwt_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qwt_qstat_t;

endpackage

>>> sv/qwt_front.sv
// Front part of the tokenizer: accepts characters, tracks the scan mode and word length,
// and pushes one queue entry for every request that produces results. Uses qwt_pkg.
`timescale 1ns / 1ps

module qwt_front #(
	parameter int MAX_WORD = qwt_pkg::MAX_WORD_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  qwt_pkg::qwt_in_t   item,
	input  qwt_pkg::qwt_qstat_t qstat,
	output logic               push,
	output qwt_pkg::qwt_entry_t push_entry
);
	import qwt_pkg::*;

	localparam int LEN_W = $clog2(MAX_WORD);

	typedef enum logic [4:0] {
		M_SKIP   = 5'b00001,
		M_PLAIN  = 5'b00010,
		M_QUOTE  = 5'b00100,
		M_BRACE  = 5'b01000,
		M_IGNORE = 5'b10000
	} mode_t;

	mode_t            mode_q, nxt_mode;
	logic [LEN_W-1:0] len_q, nxt_len, base_len;
	logic             accept, blank, take, end_w, res_push;
	logic [7:0]       tch;
	qwt_entry_t       ent;

	assign item_stall = qstat.full;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		blank    = (item.ch inside {[CH_TAB:CH_CR], CH_SPACE});
		base_len = (mode_q == M_PLAIN || mode_q == M_QUOTE || mode_q == M_BRACE) ? len_q : '0;
		nxt_mode = mode_q;
		nxt_len  = len_q;
		res_push = 1'b0;
		take     = 1'b0;
		end_w    = 1'b0;
		tch      = item.ch;
		ent      = '{res: '{kind: KIND_CHAR, word_char: 8'd0, last: 1'b1}, two: 1'b0};
		if (item.line_end) begin
			res_push = 1'b1;
			nxt_mode = M_SKIP;
			nxt_len  = '0;
			if (mode_q == M_PLAIN || mode_q == M_QUOTE || mode_q == M_BRACE) begin
				ent.res.kind = KIND_END;
				ent.res.last = 1'b0;
				ent.two      = 1'b1;
			end else begin
				ent.res.kind = KIND_LINE;
			end
		end else begin
			case (mode_q)
				M_IGNORE: begin
				end
				M_PLAIN: begin
					if (blank || item.ch == CH_COMMA) end_w = 1'b1;
					else take = 1'b1;
				end
				M_QUOTE: begin
					if (item.ch == CH_QUOTE) begin
						end_w = 1'b1;
					end else begin
						take = 1'b1;
						tch  = blank ? CH_UNDER : item.ch;
					end
				end
				M_BRACE: begin
					if (item.ch == CH_RBR) end_w = 1'b1;
					else take = 1'b1;
				end
				default: begin
					nxt_mode = M_SKIP;
					nxt_len  = '0;
					if (blank) begin
					end else if (item.ch == CH_QUOTE) begin
						nxt_mode = M_QUOTE;
					end else if (item.ch == CH_LBR) begin
						nxt_mode = M_BRACE;
					end else if (item.ch == CH_SEMI) begin
						nxt_mode = M_IGNORE;
					end else if (item.ch == CH_COMMA) begin
						end_w = 1'b1;
					end else begin
						nxt_mode = M_PLAIN;
						take     = 1'b1;
					end
				end
			endcase
			if (end_w) begin
				res_push     = 1'b1;
				ent.res.kind = KIND_END;
				nxt_mode     = M_SKIP;
				nxt_len      = '0;
			end
			if (take) begin
				if (base_len == LEN_W'(MAX_WORD - 1)) begin
					res_push     = 1'b1;
					ent.res.kind = KIND_ERR;
					nxt_mode     = M_IGNORE;
					nxt_len      = '0;
				end else begin
					nxt_len = base_len + LEN_W'(1);
					if (tch != CH_SEMI && tch != CH_LT) begin
						res_push          = 1'b1;
						ent.res.kind      = KIND_CHAR;
						ent.res.word_char = tch;
					end
				end
			end
		end
	end

	assign push       = accept && res_push;
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_SKIP;
			len_q  <= '0;
		end else if (accept) begin
			mode_q <= nxt_mode;
			len_q  <= nxt_len;
		end
	end

endmodule

>>> sv/qwt_queue.sv
// Short queue of result entries between the front and back parts of the tokenizer.
// Uses qwt_pkg for the entry type and depth.
`timescale 1ns / 1ps

module qwt_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  qwt_pkg::qwt_entry_t push_entry,
	input  logic                pop,
	output qwt_pkg::qwt_entry_t head,
	output qwt_pkg::qwt_qstat_t qstat
);
	import qwt_pkg::*;

	qwt_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + QPTR_W'(1);
			if (pop) rptr_q <= rptr_q + QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

>>> sv/qwt_back.sv
// Back part of the tokenizer: pops queue entries into the output register and
// expands an end-of-word entry at a line end into its trailing line-done result. Uses qwt_pkg.
`timescale 1ns / 1ps

module qwt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  qwt_pkg::qwt_entry_t head,
	input  qwt_pkg::qwt_qstat_t qstat,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output qwt_pkg::qwt_out_t   result
);
	import qwt_pkg::*;

	logic     valid_q, pend_q, load;
	qwt_out_t res_q;

	assign load         = !valid_q || !result_stall;
	assign pop          = load && !pend_q && !qstat.empty;
	assign result_valid = valid_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else begin
				valid_q <= !qstat.empty;
				pend_q  <= !qstat.empty && head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) res_q <= '{kind: KIND_LINE, word_char: 8'd0, last: 1'b1};
			else res_q <= head.res;
		end
	end

endmodule

>>> sv/quoted_word_tokenizer.sv
// Top level of the quoted word tokenizer: front classifier, result queue and back end.
// Depends on qwt_pkg, qwt_front, qwt_queue and qwt_back.
// The block takes one character per clock cycle and gives at most one result per cycle. A line
// end that closes an open word gives two results from a single queue entry; the four-entry queue
// between the front and the output register absorbs this, and the input stalls only while that
// queue is full. A result passes through the queue and then the output register before it
// appears on the output. MAX_WORD sets the length at which a word is cut off with an error.
`timescale 1ns / 1ps

module quoted_word_tokenizer #(
	parameter int MAX_WORD = qwt_pkg::MAX_WORD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  qwt_pkg::qwt_in_t  item,
	output logic              result_valid,
	input  logic              result_stall,
	output qwt_pkg::qwt_out_t result
);
	import qwt_pkg::*;

	logic       push, pop;
	qwt_entry_t push_entry, head;
	qwt_qstat_t qstat;

	qwt_front #(.MAX_WORD(MAX_WORD)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	qwt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	qwt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> sv/qwt_checker.sv
// Port-level checks for the quoted word tokenizer and the bind that attaches them.
// Depends on qwt_pkg and quoted_word_tokenizer.
`timescale 1ns / 1ps

module qwt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input qwt_pkg::qwt_out_t result
);
	import qwt_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("Stalled result changed.");

	a_line_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_LINE |-> result.last)
		else $error("Line done result is not last.");

	a_nonchar_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != KIND_CHAR |-> result.word_char == 8'd0)
		else $error("Non-character result carries a character.");

	a_notlast_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> result.kind == KIND_END)
		else $error("Only an end of word may be followed by more results.");

	a_line_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.last |=>
			result_valid && result.kind == KIND_LINE)
		else $error("Line done did not follow an end of word at a line end.");

endmodule

bind quoted_word_tokenizer qwt_checker u_qwt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
